// File: src/ttfr_pkg.sv
// shared types and constants for the triple terminator frame receiver
// no dependencies; imported by every module of the block
package ttfr_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned LEN_W         = 6;
   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned RSP_TDATA_W   = ((BYTE_W + LEN_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W     = RSP_TDATA_W - BYTE_W - LEN_W;
   localparam logic [BYTE_W-1:0] TERM_RESET = 8'hff;

   // one frame command from the classifier to the drain sequencer
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             ovf;
   } cmd_type;

endpackage

// File: src/ttfr_store.sv
// frame byte memory: one write port, one registered read port
// depends on ttfr_pkg
module ttfr_store
   import ttfr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_W-1:0]        rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ttfr_queue.sv
// two-entry command queue between the classifier and the drain sequencer
// depends on ttfr_pkg
module ttfr_queue
   import ttfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);

   localparam int unsigned QDEPTH = 2;

   cmd_type                     slot_ff [QDEPTH];
   logic [$clog2(QDEPTH):0]     count_ff, count_in;
   logic [$clog2(QDEPTH)-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [$clog2(QDEPTH)-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                        do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == ($clog2(QDEPTH)+1)'(QDEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/ttfr_front.sv
// byte classifier: fill count, terminator window, store writes, command issue
// depends on ttfr_pkg
module ttfr_front
   import ttfr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [BYTE_W-1:0]        req_byte,
   output logic                     req_ready,
   input  logic                     csr_valid,
   input  logic [BYTE_W-1:0]        csr_data,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [BYTE_W-1:0]        wr_data,
   output logic                     cmd_push,
   output cmd_type                  cmd_data,
   input  logic                     queue_empty,
   input  logic                     back_busy
);

   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   typedef enum logic {
      F_IDLE,
      F_FIX
   } fstate_type;

   fstate_type        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_inc;
   logic [BYTE_W-1:0] prev1_ff, prev1_in;
   logic [BYTE_W-1:0] prev2_ff, prev2_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic [BYTE_W-1:0] term_ff, term_in;
   logic              accept, enough, m0, m1, m2, done, lost, full;

   // stall during the second lost-terminator write and while the drain side still holds or reads a frame
   assign req_ready = (state_ff == F_IDLE) && queue_empty && !back_busy;
   assign accept    = req_valid && req_ready;

   // window over the newest three bytes
   assign m0       = (prev2_ff == term_ff);
   assign m1       = (prev1_ff == term_ff);
   assign m2       = (req_byte == term_ff);
   assign enough   = (fill_ff >= FILL_W'(2));
   assign done     = enough && m0 && m1 && m2;
   assign lost     = enough && m0 && !(m1 && m2);
   assign fill_inc = fill_ff + 1'b1;
   assign full     = (fill_inc == FILL_W'(DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      held_in  = held_ff;
      term_in  = csr_valid ? csr_data : term_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff[ADDR_W-1:0];
      wr_data  = req_byte;
      cmd_push = 1'b0;
      cmd_data = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               prev2_in = prev1_ff;
               prev1_in = req_byte;
               held_in  = req_byte;
               if (done) begin
                  // frame complete: payload is everything before the terminators
                  cmd_push     = 1'b1;
                  cmd_data.len = LEN_W'(fill_ff - FILL_W'(2));
                  fill_in      = '0;
               end else if (lost) begin
                  // keep only the two newest bytes at the start of the store
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = prev1_ff;
                  fill_in  = FILL_W'(2);
                  state_in = F_FIX;
               end else begin
                  wr_en = 1'b1;
                  if (full) begin
                     cmd_push     = 1'b1;
                     cmd_data.ovf = 1'b1;
                     fill_in      = '0;
                  end else begin
                     fill_in = fill_inc;
                  end
               end
            end
         end
         F_FIX: begin
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(1);
            wr_data  = held_ff;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         fill_ff  <= '0;
         term_ff  <= TERM_RESET;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         term_ff  <= term_in;
      end
      prev1_ff <= prev1_in;
      prev2_ff <= prev2_in;
      held_ff  <= held_in;
   end

endmodule

// File: src/ttfr_back.sv
// drain sequencer: reads frame payload from the store and drives result beats
// depends on ttfr_pkg
module ttfr_back
   import ttfr_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  head_cmd,
   input  logic                     queue_empty,
   output logic                     pop,
   output logic                     busy,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [BYTE_W-1:0]        rd_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BYTE_W-1:0]        rsp_byte,
   output logic                     rsp_last,
   output logic [LEN_W-1:0]         rsp_len,
   output logic                     rsp_ovf
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      B_IDLE,
      B_WAIT,
      B_SEND
   } bstate_type;

   bstate_type        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;
   logic              ovf_ff, ovf_in;
   logic              is_last;

   assign busy      = (state_ff != B_IDLE);
   assign pop       = (state_ff == B_IDLE) && !queue_empty;
   assign rsp_valid = (state_ff == B_SEND);
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;
   assign rsp_len   = olen_ff;
   assign rsp_ovf   = ovf_ff;
   assign rd_addr   = idx_in;
   assign is_last   = ((LEN_W+1)'(idx_ff) + 1'b1) == {1'b0, len_ff};

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      olen_in  = olen_ff;
      ovf_in   = ovf_ff;
      rd_en    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               len_in = head_cmd.len;
               idx_in = '0;
               if (head_cmd.ovf || head_cmd.len == '0) begin
                  // single beat: empty payload or overflow marker
                  byte_in  = '0;
                  last_in  = 1'b1;
                  olen_in  = '0;
                  ovf_in   = head_cmd.ovf;
                  state_in = B_SEND;
               end else begin
                  rd_en    = 1'b1;
                  state_in = B_WAIT;
               end
            end
         end
         B_WAIT: begin
            // read data is back from the store
            byte_in  = rd_data;
            last_in  = is_last;
            olen_in  = len_ff;
            ovf_in   = 1'b0;
            state_in = B_SEND;
         end
         B_SEND: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  rd_en    = 1'b1;
                  state_in = B_WAIT;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      olen_ff <= olen_in;
      ovf_ff  <= ovf_in;
   end

endmodule

// File: src/triple_terminator_frame_receiver_unit.sv
// top level of the triple terminator frame receiver
// depends on ttfr_pkg, ttfr_front, ttfr_queue, ttfr_store, ttfr_back
//
//  channel   direction  beat contents
//  req_      in         tdata[7:0] rx_byte
//  rsp_      out        tdata[7:0] data_byte, [13:8] payload_length; tlast last;
//                       tuser[0] overflow
//  csr_      in         data[7:0] terminator_byte
//
// an input byte is accepted in F_IDLE; when a lost terminator moves the newest two bytes
// to the head of the store, F_FIX writes the second one and stalls the input as well;
// the front stalls while a frame drains; draining runs B_IDLE (pick up the command, issue
// the first read), then B_WAIT (load) and B_SEND (handshake) per payload beat; a single-beat
// result goes from B_IDLE to B_SEND; reset is synchronous; the store has no clearing pass,
// only written entries are read back; the result register holds its beat for any rsp_tready stall
module triple_terminator_frame_receiver_unit
   import ttfr_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // rx_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // data_byte, payload_length, zero pad
   output logic                   rsp_tlast,
   output logic [0:0]             rsp_tuser,   // overflow
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [BYTE_W-1:0]      csr_data
);

   localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

   logic              wr_en, rd_en, cmd_push, cmd_pop, q_empty, q_full, back_busy;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data, rsp_byte;
   logic [LEN_W-1:0]  rsp_len;
   logic              rsp_ovf;
   cmd_type           cmd_in, cmd_head;

   // register writes are always taken
   assign csr_ready = 1'b1;

   ttfr_front #(.DEPTH(BUFFER_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_byte    (req_tdata),
      .req_ready   (req_tready),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in),
      .queue_empty (q_empty),
      .back_busy   (back_busy)
   );

   ttfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push && !q_full),
      .push_cmd (cmd_in),
      .pop      (cmd_pop),
      .head_cmd (cmd_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   ttfr_store #(.DEPTH(BUFFER_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ttfr_back #(.DEPTH(BUFFER_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (cmd_head),
      .queue_empty (q_empty),
      .pop         (cmd_pop),
      .busy        (back_busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_byte    (rsp_byte),
      .rsp_last    (rsp_tlast),
      .rsp_len     (rsp_len),
      .rsp_ovf     (rsp_ovf)
   );

   // result beat packing
   assign rsp_tdata = {RSP_PAD_W'(0), rsp_len, rsp_byte};
   assign rsp_tuser = rsp_ovf;

endmodule
